// ===== src/quaternion_to_euler_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for quaternion_to_euler
// Same-cycle and next-cycle implications, sampled on the rising clock edge
// and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ASSERT_SVH
`define QUATERNION_TO_EULER_ASSERT_SVH

// Check cons in the cycle where ante holds.
`define QTE_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante holds.
`define QTE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg
// Types, widths and the arctangent table shared by the quaternion to Euler
// angle pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

   localparam int QUAT_W            = 16;
   localparam int ANG_W             = 16;
   localparam int PROD_W            = 32;  // one component product
   localparam int SUM_W             = 34;  // 2*(a*b +/- c*d) and 1 - 2*(..)
   localparam int MAG_W             = 28;  // |sin pitch| below one
   localparam int ROOT_W            = 29;  // floor sqrt of up to 2^56
   localparam int SQ_W              = 58;  // square root working width
   localparam int CORD_W            = 38;  // CORDIC x/y with gain headroom
   localparam int Z_W               = 32;  // 2^32 units per turn
   localparam int LANES             = 3;
   localparam int LANE_PITCH        = 0;
   localparam int LANE_YAW          = 1;
   localparam int LANE_ROLL         = 2;
   localparam int ATAN_LEN          = 24;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam logic signed [SUM_W-1:0] Q28_ONE = SUM_W'(1) <<< 28;
   localparam logic [SQ_W-1:0]         SQ_TOP  = SQ_W'(1) << (2 * (ROOT_W - 1));
   localparam logic [Z_W-1:0]          Z_HALF  = Z_W'(1) << (Z_W - 1);
   localparam logic [Z_W-1:0]          Z_ROUND = Z_W'(1) << (Z_W - ANG_W - 1);
   localparam logic signed [ANG_W-1:0] ANG_QUARTER_POS = ANG_W'(16384);
   localparam logic signed [ANG_W-1:0] ANG_QUARTER_NEG = -ANG_W'(16384);

   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic signed [CORD_W-1:0] coord_type;

   typedef enum logic [1:0] {
      SAT_NONE,
      SAT_POS,
      SAT_NEG
   } sat_type;

   typedef struct packed {
      logic signed [QUAT_W-1:0] quat_w;
      logic signed [QUAT_W-1:0] quat_x;
      logic signed [QUAT_W-1:0] quat_y;
      logic signed [QUAT_W-1:0] quat_z;
   } req_type;

   typedef struct packed {
      logic signed [ANG_W-1:0] pitch_angle;
      logic signed [ANG_W-1:0] yaw_angle;
      logic signed [ANG_W-1:0] roll_angle;
   } rsp_type;

   // Sine/cosine terms that ride alongside the square root
   typedef struct packed {
      sat_type sat;
      sum_type sp;
      sum_type sy;
      sum_type cy;
      sum_type sr;
      sum_type cr;
   } side_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } vec_type;

   // atan(2^-i), 2^32 units per turn
   function automatic logic [Z_W-1:0] atan_entry(input logic [4:0] idx);
      logic [Z_W-1:0] val;
      unique case (idx)
         5'd0:    val = 32'd536870912;
         5'd1:    val = 32'd316933406;
         5'd2:    val = 32'd167458907;
         5'd3:    val = 32'd85004756;
         5'd4:    val = 32'd42667331;
         5'd5:    val = 32'd21354465;
         5'd6:    val = 32'd10679838;
         5'd7:    val = 32'd5340245;
         5'd8:    val = 32'd2670163;
         5'd9:    val = 32'd1335087;
         5'd10:   val = 32'd667544;
         5'd11:   val = 32'd333772;
         5'd12:   val = 32'd166886;
         5'd13:   val = 32'd83443;
         5'd14:   val = 32'd41722;
         5'd15:   val = 32'd20861;
         5'd16:   val = 32'd10430;
         5'd17:   val = 32'd5215;
         5'd18:   val = 32'd2608;
         5'd19:   val = 32'd1304;
         5'd20:   val = 32'd652;
         5'd21:   val = 32'd326;
         5'd22:   val = 32'd163;
         5'd23:   val = 32'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== src/qte_stream_if.sv =====
// ----------------------------------------------------------------------------
// qte_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface qte_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/qte_front.sv =====
// ----------------------------------------------------------------------------
// qte_front
// Three stages: component products, sine/cosine sums with pitch saturation,
// and 2^56 - sin^2 for the pitch cosine.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  qte_pkg::req_type          in_word,
   output logic                      out_valid,
   output logic [qte_pkg::SQ_W-1:0]  out_n,
   output qte_pkg::side_type         out_side
);
   import qte_pkg::*;

   logic [2:0] valid_ff;

   // stage 1: products
   logic signed [PROD_W-1:0] wx_ff, yz_ff, wy_ff, zx_ff, wz_ff, xy_ff;
   logic signed [PROD_W-1:0] xx_ff, yy_ff, zz_ff;

   // stage 2: sums
   side_type         side2_in, side2_ff;
   logic [MAG_W-1:0] mag_in, mag_ff;
   sum_type          sp_abs;

   // stage 3: remainder under the square root
   logic [2*MAG_W-1:0] sq_w;
   logic [SQ_W-1:0]    n_ff;
   side_type           side3_ff;

   always_comb begin
      side2_in.sp = (SUM_W'(wx_ff) - SUM_W'(yz_ff)) <<< 1;
      side2_in.sy = (SUM_W'(wy_ff) + SUM_W'(zx_ff)) <<< 1;
      side2_in.cy = Q28_ONE - ((SUM_W'(xx_ff) + SUM_W'(yy_ff)) <<< 1);
      side2_in.sr = (SUM_W'(wz_ff) + SUM_W'(xy_ff)) <<< 1;
      side2_in.cr = Q28_ONE - ((SUM_W'(zz_ff) + SUM_W'(xx_ff)) <<< 1);
      sp_abs      = (side2_in.sp < 0) ? -side2_in.sp : side2_in.sp;
      priority if (side2_in.sp >= Q28_ONE) begin
         side2_in.sat = SAT_POS;
      end else if (side2_in.sp <= -Q28_ONE) begin
         side2_in.sat = SAT_NEG;
      end else begin
         side2_in.sat = SAT_NONE;
      end
      // zero the square when saturated so the root stays defined
      mag_in = (side2_in.sat == SAT_NONE) ? sp_abs[MAG_W-1:0] : '0;
   end

   assign sq_w = mag_ff * mag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff    <= PROD_W'(in_word.quat_w) * PROD_W'(in_word.quat_x);
         yz_ff    <= PROD_W'(in_word.quat_y) * PROD_W'(in_word.quat_z);
         wy_ff    <= PROD_W'(in_word.quat_w) * PROD_W'(in_word.quat_y);
         zx_ff    <= PROD_W'(in_word.quat_z) * PROD_W'(in_word.quat_x);
         wz_ff    <= PROD_W'(in_word.quat_w) * PROD_W'(in_word.quat_z);
         xy_ff    <= PROD_W'(in_word.quat_x) * PROD_W'(in_word.quat_y);
         xx_ff    <= PROD_W'(in_word.quat_x) * PROD_W'(in_word.quat_x);
         yy_ff    <= PROD_W'(in_word.quat_y) * PROD_W'(in_word.quat_y);
         zz_ff    <= PROD_W'(in_word.quat_z) * PROD_W'(in_word.quat_z);
         side2_ff <= side2_in;
         mag_ff   <= mag_in;
         n_ff     <= SQ_TOP - SQ_W'(sq_w);
         side3_ff <= side2_ff;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_n     = n_ff;
   assign out_side  = side3_ff;

endmodule

`default_nettype wire

// ===== src/qte_isqrt.sv =====
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined floor square root, one root bit per stage; the yaw/roll terms
// travel alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [qte_pkg::SQ_W-1:0]   in_n,
   input  qte_pkg::side_type          in_side,
   output logic                       out_valid,
   output logic [qte_pkg::ROOT_W-1:0] out_root,
   output qte_pkg::side_type          out_side
);
   import qte_pkg::*;

   logic [ROOT_W-1:0] valid_ff;
   logic [SQ_W-1:0]   n_ff   [ROOT_W];
   logic [SQ_W-1:0]   r_ff   [ROOT_W];
   logic [SQ_W-1:0]   n_in   [ROOT_W];
   logic [SQ_W-1:0]   r_in   [ROOT_W];
   side_type          side_ff [ROOT_W];

   for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_W - 1 - j));
      logic [SQ_W-1:0] n_prev, r_prev, trial;
      if (j == 0) begin : g_first
         assign n_prev = in_n;
         assign r_prev = '0;
      end else begin : g_rest
         assign n_prev = n_ff[j-1];
         assign r_prev = r_ff[j-1];
      end
      assign trial = r_prev + BIT;
      always_comb begin
         if (n_prev >= trial) begin
            n_in[j] = n_prev - trial;
            r_in[j] = (r_prev >> 1) + BIT;
         end else begin
            n_in[j] = n_prev;
            r_in[j] = r_prev >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[ROOT_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < ROOT_W; j++) begin
            n_ff[j] <= n_in[j];
            r_ff[j] <= r_in[j];
         end
         side_ff[0] <= in_side;
         for (int j = 1; j < ROOT_W; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = r_ff[ROOT_W-1][ROOT_W-1:0];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

`default_nettype wire

// ===== src/qte_cordic.sv =====
// ----------------------------------------------------------------------------
// qte_cordic
// Three-lane vectoring CORDIC: a half-plane fold stage, then one
// micro-rotation per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cordic #(
   parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            en,
   input  logic                                            in_valid,
   input  qte_pkg::sat_type                                in_sat,
   input  qte_pkg::vec_type [qte_pkg::LANES-1:0]           in_vec,
   output logic                                            out_valid,
   output qte_pkg::sat_type                                out_sat,
   output logic [qte_pkg::LANES-1:0][qte_pkg::Z_W-1:0]     out_z,
   output logic [qte_pkg::LANES-1:0]                       out_zero
);
   import qte_pkg::*;

   logic [STAGES:0] valid_ff;
   sat_type         sat_ff  [STAGES+1];
   coord_type       x_ff    [STAGES+1][LANES];
   coord_type       y_ff    [STAGES+1][LANES];
   logic [Z_W-1:0]  z_ff    [STAGES+1][LANES];
   logic            zero_ff [STAGES+1][LANES];
   coord_type       x_in    [STAGES+1][LANES];
   coord_type       y_in    [STAGES+1][LANES];
   logic [Z_W-1:0]  z_in    [STAGES+1][LANES];

   // fold the left half-plane over by half a turn
   for (genvar l = 0; l < LANES; l++) begin : g_fold
      always_comb begin
         if (in_vec[l].x < 0) begin
            x_in[0][l] = -in_vec[l].x;
            y_in[0][l] = -in_vec[l].y;
            z_in[0][l] = Z_HALF;
         end else begin
            x_in[0][l] = in_vec[l].x;
            y_in[0][l] = in_vec[l].y;
            z_in[0][l] = '0;
         end
      end
   end

   for (genvar s = 0; s < STAGES; s++) begin : g_iter
      localparam logic [Z_W-1:0] ATAN = atan_entry(5'(s));
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         always_comb begin
            if (y_ff[s][l] > 0) begin
               x_in[s+1][l] = x_ff[s][l] + (y_ff[s][l] >>> s);
               y_in[s+1][l] = y_ff[s][l] - (x_ff[s][l] >>> s);
               z_in[s+1][l] = z_ff[s][l] + ATAN;
            end else begin
               x_in[s+1][l] = x_ff[s][l] - (y_ff[s][l] >>> s);
               y_in[s+1][l] = y_ff[s][l] + (x_ff[s][l] >>> s);
               z_in[s+1][l] = z_ff[s][l] - ATAN;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[STAGES-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sat_ff[0] <= in_sat;
         for (int l = 0; l < LANES; l++) begin
            zero_ff[0][l] <= (in_vec[l].x == '0) && (in_vec[l].y == '0);
         end
         for (int s = 1; s <= STAGES; s++) begin
            sat_ff[s] <= sat_ff[s-1];
            for (int l = 0; l < LANES; l++) begin
               zero_ff[s][l] <= zero_ff[s-1][l];
            end
         end
         for (int s = 0; s <= STAGES; s++) begin
            for (int l = 0; l < LANES; l++) begin
               x_ff[s][l] <= x_in[s][l];
               y_ff[s][l] <= y_in[s][l];
               z_ff[s][l] <= z_in[s][l];
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_z[l]    = z_ff[STAGES][l];
         out_zero[l] = zero_ff[STAGES][l];
      end
   end

   assign out_valid = valid_ff[STAGES];
   assign out_sat   = sat_ff[STAGES];

endmodule

`default_nettype wire

// ===== src/quaternion_to_euler.sv =====
// Quaternion to Euler angle converter.
// req_chan takes one word per quaternion (quat_w, quat_x, quat_y, quat_z,
// signed Q1.14); rsp_chan returns one word with pitch, yaw and roll in
// binary angle units (65536 per turn). Both are valid/ready channels; a word
// moves on a rising edge where valid and ready are both high.
// The pipeline holds three product/sum stages, 29 square-root stages for
// the pitch cosine, one half-plane fold stage, one stage per CORDIC
// micro-rotation and the output register. Throughput is one word per cycle
// while the receiver takes each word; every stage is a register of the one
// pipeline, so a new quaternion enters each cycle unless the output stalls.
// Reset clears all valid bits, including the output valid; the pipeline is
// empty and ready right after it.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// req_chan.ready drops in the same cycle; nothing is dropped or repeated.
// Pitch saturates to plus or minus a quarter turn when |2(wx - yz)| >= 1.
// ----------------------------------------------------------------------------
// quaternion_to_euler
// Top level: front stages, square root, three-lane CORDIC, output rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler #(
   parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   qte_stream_if.sink          req_chan,
   qte_stream_if.source        rsp_chan
);
   import qte_pkg::*;

   // pipeline advances whenever the output register is free or being taken
   logic en;

   logic              front_valid;
   logic [SQ_W-1:0]   front_n;
   side_type          front_side;

   logic              root_valid;
   logic [ROOT_W-1:0] root;
   side_type          root_side;

   vec_type [LANES-1:0]          cord_vec;
   logic                         cord_valid;
   sat_type                      cord_sat;
   logic [LANES-1:0][Z_W-1:0]    cord_z;
   logic [LANES-1:0]             cord_zero;

   logic                         rsp_valid_ff;
   rsp_type                      rsp_ff;
   rsp_type                      rsp_in;
   logic [LANES-1:0][ANG_W-1:0]  ang;

   assign en             = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   qte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .in_word   (req_chan.payload),
      .out_valid (front_valid),
      .out_n     (front_n),
      .out_side  (front_side)
   );

   qte_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_n      (front_n),
      .in_side   (front_side),
      .out_valid (root_valid),
      .out_root  (root),
      .out_side  (root_side)
   );

   // pitch = atan2(sin, sqrt(1 - sin^2)); yaw and roll straight atan2
   always_comb begin
      cord_vec[LANE_PITCH].x = CORD_W'(root);
      cord_vec[LANE_PITCH].y = CORD_W'(root_side.sp);
      cord_vec[LANE_YAW].x   = CORD_W'(root_side.cy);
      cord_vec[LANE_YAW].y   = CORD_W'(root_side.sy);
      cord_vec[LANE_ROLL].x  = CORD_W'(root_side.cr);
      cord_vec[LANE_ROLL].y  = CORD_W'(root_side.sr);
   end

   qte_cordic #(
      .STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (root_valid),
      .in_sat    (root_side.sat),
      .in_vec    (cord_vec),
      .out_valid (cord_valid),
      .out_sat   (cord_sat),
      .out_z     (cord_z),
      .out_zero  (cord_zero)
   );

   // round 2^32 to 2^16 units per turn; a zero vector reads as angle zero
   always_comb begin
      logic [Z_W-1:0] z_round;
      for (int l = 0; l < LANES; l++) begin
         z_round = cord_z[l] + Z_ROUND;
         ang[l]  = cord_zero[l] ? '0 : z_round[Z_W-1 -: ANG_W];
      end
      unique case (cord_sat)
         SAT_POS:  rsp_in.pitch_angle = ANG_QUARTER_POS;
         SAT_NEG:  rsp_in.pitch_angle = ANG_QUARTER_NEG;
         SAT_NONE: rsp_in.pitch_angle = ang[LANE_PITCH];
         default:  rsp_in.pitch_angle = ang[LANE_PITCH];
      endcase
      rsp_in.yaw_angle  = ang[LANE_YAW];
      rsp_in.roll_angle = ang[LANE_ROLL];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= cord_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule

`default_nettype wire

// ===== src/qte_checker.sv =====
// ----------------------------------------------------------------------------
// qte_checker
// Port-level checks on the converter's channels and pitch range.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quaternion_to_euler_assert.svh"

module qte_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input qte_pkg::rsp_type               rsp_word
);
   import qte_pkg::*;

   logic signed [ANG_W-1:0] pitch;
   logic                    pitch_ok;

   assign pitch    = rsp_word.pitch_angle;
   assign pitch_ok = (pitch <= ANG_QUARTER_POS) && (pitch >= ANG_QUARTER_NEG);

   `QTE_ASSERT_IMPL(a_pitch_range, rsp_valid, pitch_ok, "pitch beyond a quarter turn")
   `QTE_ASSERT_IMPL(a_ready_when_empty, !rsp_valid, req_ready, "input stalled with output empty")
   `QTE_ASSERT_IMPL(a_stall_backs_up, rsp_valid && !rsp_ready, !req_ready, "input taken during stall")
   `QTE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "stalled word changed")

   // no input word moves while the output word is stalled
   logic req_seen;
   assign req_seen = req_valid && req_ready;
   `QTE_ASSERT_NEXT(a_no_accept_in_stall, req_seen && rsp_valid && !rsp_ready, 1'b0, "word accepted while stalled")

endmodule

bind quaternion_to_euler qte_checker u_qte_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_word  (rsp_chan.payload)
);

`default_nettype wire

// ===== test/tb_quaternion_to_euler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler
// Streams quaternions through the converter, predicts pitch/yaw/roll with a
// bit-exact CORDIC model and checks every result word in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_quaternion_to_euler;
   import qte_pkg::*;

   localparam int STAGES     = CORDIC_STAGES_DEF;
   localparam int LATENCY    = STAGES + 34;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   qte_stream_if #(.payload_type(req_type)) req_chan ();
   qte_stream_if #(.payload_type(rsp_type)) rsp_chan ();

   quaternion_to_euler #(.CORDIC_STAGES(STAGES)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #1 clock = ~clock;

   // Expected angle words, oldest first
   rsp_type angles_due[$];
   int      errors     = 0;
   int      send_idle  = 0;   // percent of cycles the sender holds off
   int      recv_idle  = 0;   // percent of cycles the receiver holds off
   bit      recv_block = 1'b0;
   int      idle_count = 0;

   // Arctangent of 2^-i, 2^32 units per turn
   function automatic longint unsigned atan_step(int i);
      longint unsigned tab[24] = '{536870912, 316933406, 167458907, 85004756,
         42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
         333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652,
         326, 163, 81};
      return tab[i];
   endfunction

   // floor(v / 2^s); arithmetic shift of a signed longint is exactly that
   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint unsigned floor_root(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Vectoring CORDIC, result in 2^32 units per turn
   function automatic logic [31:0] cordic_angle(longint y, longint x);
      logic [31:0] z;
      longint      dx;
      longint      dy;
      z = '0;
      if (x == 0 && y == 0) return '0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 32'h8000_0000;
      end
      for (int i = 0; i < STAGES && i < 24; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (y > 0) begin
            x += dx;
            y -= dy;
            z += 32'(atan_step(i));
         end else begin
            x -= dx;
            y += dy;
            z -= 32'(atan_step(i));
         end
      end
      return z;
   endfunction

   function automatic logic [15:0] round_turn(logic [31:0] z);
      logic [31:0] t;
      t = z + 32'h8000;
      return t[31:16];
   endfunction

   function automatic rsp_type euler_of(req_type q);
      rsp_type r;
      longint  w, x, y, z, sp, one;
      longint unsigned rem;
      w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
      one = 64'sd1 <<< 28;
      sp = 2 * (w * x - y * z);
      if (sp >= one) begin
         r.pitch_angle = ANG_QUARTER_POS;
      end else if (sp <= -one) begin
         r.pitch_angle = ANG_QUARTER_NEG;
      end else begin
         rem = (64'd1 << 56) - 64'(sp * sp);
         r.pitch_angle = round_turn(cordic_angle(sp, longint'(floor_root(rem))));
      end
      r.yaw_angle  = round_turn(cordic_angle(2 * (w * y + z * x),
                                             one - 2 * (x * x + y * y)));
      r.roll_angle = round_turn(cordic_angle(2 * (w * z + x * y),
                                             one - 2 * (z * z + x * x)));
      return r;
   endfunction

   // Offer one quaternion and hold it until accepted; drop valid only while idling
   task automatic send_quat(req_type q);
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= q;
      do @(posedge clock); while (!req_chan.ready);
      angles_due.push_back(euler_of(q));
   endtask

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(3))
         0:       return 16'($urandom_range(32768) - 16384);
         1:       return 16'($urandom);
         default: return 16'($urandom_range(4096) - 2048);
      endcase
   endfunction

   // Roughly unit quaternion with random sign and direction
   function automatic req_type rand_unit();
      real a, b, c, d, n;
      req_type q;
      a = $urandom_range(2000) - 1000.0; b = $urandom_range(2000) - 1000.0;
      c = $urandom_range(2000) - 1000.0; d = $urandom_range(2000) - 1000.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n == 0.0) n = 1.0;
      q.quat_w = 16'($rtoi(a / n * 16384.0));
      q.quat_x = 16'($rtoi(b / n * 16384.0));
      q.quat_y = 16'($rtoi(c / n * 16384.0));
      q.quat_z = 16'($rtoi(d / n * 16384.0));
      return q;
   endfunction

   task automatic test_directed();
      req_type q;
      q = '{16384, 0, 0, 0};         send_quat(q);   // identity
      q = '{0, 0, 0, 0};             send_quat(q);   // all-zero quaternion
      q = '{16384, 8192, 0, 0};      send_quat(q);   // pitch at +1: saturate
      q = '{16384, -8192, 0, 0};     send_quat(q);   // pitch at -1: saturate
      q = '{16384, 8191, 0, 0};      send_quat(q);   // pitch just under one
      q = '{0, 0, 11585, -11585};    send_quat(q);
      q = '{0, 16384, 0, 0};         send_quat(q);   // half turn roll
      q = '{0, 0, 16384, 0};         send_quat(q);   // half turn yaw
      q = '{0, 0, 0, 16384};         send_quat(q);
      q = '{-16384, 0, 0, 0};        send_quat(q);
      q = '{16384, 16384, 16384, 16384};     send_quat(q);
      q = '{-16384, -16384, -16384, -16384}; send_quat(q);
      q = '{16'h7fff, 16'h7fff, 16'h8000, 16'h7fff}; send_quat(q); // out of range
      q = '{16'h8000, 16'h8000, 16'h8000, 16'h8000}; send_quat(q);
      q = '{16'hffff, 16'h0001, 16'haaaa, 16'h5555}; send_quat(q);
      q = '{16'h5555, 16'haaaa, 16'h0001, 16'hffff}; send_quat(q);
   endtask

   task automatic test_random(int count);
      req_type q;
      repeat (count) begin
         if ($urandom_range(9) < 7) q = rand_unit();
         else q = '{rand_comp(), rand_comp(), rand_comp(), rand_comp()};
         send_quat(q);
      end
   endtask

   // Receiver blocked for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      recv_block = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            recv_block = 1'b0;
         end
         test_random(150);
      join
   endtask

   // Receiver ready, randomly held low; one assignment per edge
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !recv_block && ($urandom_range(99) >= recv_idle);
      end
   end

   // Check each accepted result word against the oldest expectation
   always @(posedge clock) begin
      rsp_type exp_w;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (angles_due.size() == 0) begin
            $display("%0t: unexpected word %h", $time, rsp_chan.payload);
            errors++;
         end else begin
            exp_w = angles_due.pop_front();
            if (exp_w.pitch_angle !== rsp_chan.payload.pitch_angle) begin
               $display("%0t: pitch expected %0d actual %0d", $time,
                        exp_w.pitch_angle, rsp_chan.payload.pitch_angle);
               errors++;
            end
            if (exp_w.yaw_angle !== rsp_chan.payload.yaw_angle) begin
               $display("%0t: yaw expected %0d actual %0d", $time,
                        exp_w.yaw_angle, rsp_chan.payload.yaw_angle);
               errors++;
            end
            if (exp_w.roll_angle !== rsp_chan.payload.roll_angle) begin
               $display("%0t: roll expected %0d actual %0d", $time,
                        exp_w.roll_angle, rsp_chan.payload.roll_angle);
               errors++;
            end
         end
      end
   end

   // Watchdog: count cycles with no word moving on either channel
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
         $display("** quaternion_to_euler: FAILED **");
         $finish;
      end
   end

   initial begin
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sender idles lightly, receiver heavily
      send_idle = 14; recv_idle = 82;
      test_directed();
      test_random(600);
      // Swap the idling
      send_idle = 82; recv_idle = 14;
      test_random(500);
      // Full rate, then a long receiver hold-off
      send_idle = 0; recv_idle = 0;
      test_random(550);
      test_backpressure();
      req_chan.valid <= 1'b0;

      // Drain, then let the pipeline settle
      while (angles_due.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (errors == 0)
         $display("** quaternion_to_euler: PASSED **");
      else
         $display("** quaternion_to_euler: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
